// File: hw/rtl/pap_pkg.sv
// Shared types and constants for the pitch accumulator with pendulum swing.
`default_nettype none

package pap_pkg;

  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned SUM_W   = 18;
  localparam int unsigned SINE_W  = 10;

  // 0.1 / (2*pi) of a turn in Q32
  localparam longint unsigned SPEED_COEF_Q32 = 64'd68356571;
  localparam int unsigned     COEF_W         = 27;

  // Sine polynomial coefficients, Q16
  localparam longint unsigned SIN_C1 = 64'd102943;
  localparam longint unsigned SIN_C3 = 64'd42047;
  localparam longint unsigned SIN_C5 = 64'd4640;

  localparam logic signed [LEVEL_W-1:0] MIN_LIMIT_RST   = -16'sd3072;
  localparam logic signed [LEVEL_W-1:0] MAX_LIMIT_RST   = 16'sd3072;
  localparam logic signed [LEVEL_W-1:0] SWING_SPEED_RST = 16'sd256;

  typedef logic signed [LEVEL_W-1:0] level_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [SINE_W-1:0]  sine_t;

  typedef enum logic [1:0] {
    REG_PENDULUM_MODE = 2'd0,
    REG_MIN_LIMIT     = 2'd1,
    REG_MAX_LIMIT     = 2'd2,
    REG_SWING_SPEED   = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_STEP    = 1'b0,
    OP_RESTART = 1'b1
  } opcode_t;

endpackage

`default_nettype wire

// File: hw/rtl/pitch_accumulator_pendulum.sv
// Top level: saturating Q8.8 pitch accumulator with pendulum swing term.
//
// Input stream s_*: s_tuser carries the opcode (step or restart), s_tdata the
// signed Q8.8 step offset. Output stream m_*: m_tdata carries the clamped
// level, m_tuser the flag that the sum hit a limit. Every request produces
// exactly one result.
// The level, clamp and state update are computed combinationally from
// the accepted request and land in the output register at the same edge.
// Throughput is one request per cycle while m_tready is high; the sine ROM
// is read from the next phase, so its registered output always matches the phase.
// When the receiver stalls, the output register holds its result and
// s_tready drops until the result is taken; with m_tready high the block
// streams continuously.
// Reset clears the level, phase and direction, loads the limit and speed
// defaults (-12.0, +12.0, 1.0 in Q8.8), selects plain mode and empties the
// output register. Configuration writes through cfg_* take effect at the
// next edge; the user must make them only while the stream is idle, as the block does not enforce it.
`default_nettype none

module pitch_accumulator_pendulum #(
  parameter int unsigned SINE_TABLE_ENTRIES = 1024,
  parameter int unsigned PHASE_BITS         = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [pap_pkg::LEVEL_W-1:0]   s_tdata,   // [15:0] step_offset
  input  wire logic [0:0]                    s_tuser,   // [0] opcode
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [pap_pkg::LEVEL_W-1:0]        m_tdata,   // [15:0] level
  output logic [0:0]                         m_tuser,   // [0] hit_limit
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_addr,
  input  wire logic [pap_pkg::LEVEL_W-1:0]   cfg_wdata
);

  import pap_pkg::*;

  localparam int unsigned IDX_W   = $clog2(SINE_TABLE_ENTRIES);
  localparam int unsigned N_W     = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int unsigned MAG_W   = LEVEL_W + 1;
  localparam int unsigned PROD_W  = MAG_W + COEF_W;
  localparam int unsigned INC_SH  = 40 - PHASE_BITS;

  typedef sine_t rom_t [SINE_TABLE_ENTRIES];

  function automatic sine_t sine_entry(int unsigned idx);
    longint unsigned q4, quad, r, a, u, u2, u4, poly, s, q;
    q4   = 64'(idx % SINE_TABLE_ENTRIES) * 4;
    quad = (q4 / SINE_TABLE_ENTRIES) & 64'd3;
    r    = q4 % SINE_TABLE_ENTRIES;
    a    = quad[0] ? 64'(SINE_TABLE_ENTRIES) - r : r;
    u    = (a << 16) / SINE_TABLE_ENTRIES;
    u2   = (u * u) >> 16;
    u4   = (u2 * u2) >> 16;
    poly = SIN_C1 - ((SIN_C3 * u2) >> 16) + ((SIN_C5 * u4) >> 16);
    s    = (u * poly) >> 16;
    q    = (s + 64'd128) >> 8;
    if (q > 64'd256) begin
      q = 64'd256;
    end
    return quad[1] ? -SINE_W'(q) : SINE_W'(q);
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int unsigned i = 0; i < SINE_TABLE_ENTRIES; i++) begin
      t[i] = sine_entry(i);
    end
    return t;
  endfunction

  function automatic logic [PHASE_BITS-1:0] speed_to_inc(level_t speed);
    logic [MAG_W-1:0]      mag;
    logic [PROD_W-1:0]     prod;
    logic [PHASE_BITS-1:0] inc_mag;
    mag     = speed[LEVEL_W-1] ? -MAG_W'(speed) : MAG_W'(speed);
    prod    = PROD_W'(mag) * PROD_W'(SPEED_COEF_Q32);
    inc_mag = prod[INC_SH +: PHASE_BITS];
    return speed[LEVEL_W-1] ? -inc_mag : inc_mag;
  endfunction

  localparam rom_t SINE_ROM = build_rom();
  localparam logic [PHASE_BITS-1:0] INC_RST = speed_to_inc(SWING_SPEED_RST);

  logic                        pendulum_mode;
  level_t                      min_limit;
  level_t                      max_limit;
  logic [PHASE_BITS-1:0]       phase_inc;

  level_t                      level_store;
  logic                        swing_sign;
  logic                        swing_sign_next;
  logic [PHASE_BITS-1:0]       swing_phase;
  logic [PHASE_BITS-1:0]       swing_phase_next;
  sine_t                       sine_q;

  logic                        accept;
  logic                        restart;
  sum_t                        swing_term;
  sum_t                        sum;
  level_t                      level_next;
  logic                        hit;
  logic [PHASE_BITS+N_W-1:0]   idx_prod;
  logic [IDX_W-1:0]            rom_idx;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign restart  = (opcode_t'(s_tuser[0]) == OP_RESTART);

  always_comb begin
    swing_term = pendulum_mode ? (swing_sign ? -SUM_W'(sine_q) : SUM_W'(sine_q)) : '0;
    sum = SUM_W'(level_store) + SUM_W'($signed(s_tdata)) + swing_term;
    if (sum > SUM_W'(max_limit)) begin
      level_next = max_limit;
      hit        = 1'b1;
    end else if (sum < SUM_W'(min_limit)) begin
      level_next = min_limit;
      hit        = 1'b1;
    end else begin
      level_next = sum[LEVEL_W-1:0];
      hit        = 1'b0;
    end
  end

  always_comb begin
    swing_phase_next = swing_phase;
    swing_sign_next  = swing_sign;
    if (rst) begin
      swing_phase_next = '0;
      swing_sign_next  = 1'b0;
    end else if (accept) begin
      if (restart) begin
        swing_phase_next = '0;
        swing_sign_next  = 1'b0;
      end else if (pendulum_mode) begin
        swing_phase_next = swing_phase + phase_inc;
        swing_sign_next  = swing_sign ^ hit;
      end
    end
  end

  assign idx_prod = (PHASE_BITS+N_W)'(swing_phase_next) *
                    (PHASE_BITS+N_W)'(SINE_TABLE_ENTRIES);
  assign rom_idx  = idx_prod[PHASE_BITS +: IDX_W];

  always_ff @(posedge clk) begin
    sine_q <= SINE_ROM[rom_idx];
  end

  always_ff @(posedge clk) begin
    swing_phase <= swing_phase_next;
    swing_sign  <= swing_sign_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pendulum_mode <= 1'b0;
      min_limit     <= MIN_LIMIT_RST;
      max_limit     <= MAX_LIMIT_RST;
      phase_inc     <= INC_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_PENDULUM_MODE: pendulum_mode <= cfg_wdata[0];
        REG_MIN_LIMIT:     min_limit     <= cfg_wdata;
        REG_MAX_LIMIT:     max_limit     <= cfg_wdata;
        REG_SWING_SPEED:   phase_inc     <= speed_to_inc(cfg_wdata);
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_store <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (accept) begin
        level_store <= restart ? '0 : level_next;
        m_tvalid    <= 1'b1;
      end else if (m_tready) begin
        m_tvalid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata    <= restart ? '0 : level_next;
      m_tuser[0] <= restart ? 1'b0 : hit;
    end
  end

endmodule

`default_nettype wire
